@@ rtl/core/bli_pkg.sv @@
// Shared constants, reset values and stage types for the battery level interpolator.
package bli_pkg;

  localparam int ADC_W     = 14;
  localparam int MV_OUT_W  = 12;
  localparam int TENTHS_W  = 6;
  localparam int LEVEL_W   = 8;

  localparam int REG_COUNT = 8;
  localparam int CFG_IDX_W = 3;
  localparam int BP_W      = 20;
  localparam int BP_MV_W   = 12;
  localparam int CAP_W     = 8;

  localparam int FULL_SCALE_MV = 3600;

  // Rounded divide by 100 done as a multiply by a scaled reciprocal;
  // exact for every dividend below 2**TEN_X_W.
  localparam int TENTHS_ROUND = 50;
  localparam int TEN_X_W      = 19;
  localparam int RECIP_W      = 20;
  localparam int TENTHS_RECIP = 671089;
  localparam int TENTHS_SHIFT = 26;

  // Interpolation divide: numerator, quotient bits and bits resolved per stage.
  localparam int NUM_W    = BP_MV_W + CAP_W;
  localparam int Q_W      = CAP_W;
  localparam int DIV_STEP = 2;
  localparam int DIV_ST   = Q_W / DIV_STEP;

  localparam logic [BP_W-1:0] BP_RESET [REG_COUNT] = '{
    20'd768200, 20'd742560, 20'd716920, 20'd691280,
    20'd665660, 20'd640040, 20'd614420, 20'd512000
  };

  typedef struct packed {
    logic [NUM_W-1:0]    rem;
    logic [BP_MV_W-1:0]  wid;
    logic [Q_W-1:0]      quo;
    logic                neg;
    logic [CAP_W-1:0]    cap;
    logic [TENTHS_W-1:0] ten;
    logic [MV_OUT_W-1:0] mvo;
  } div_t;

endpackage

@@ rtl/core/bli_if.sv @@
// Request channels of the battery level interpolator: samples, results, register writes.
interface bli_in_if;
  import bli_pkg::*;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bli_out_if;
  import bli_pkg::*;
  logic                valid;
  logic                ready;
  logic [MV_OUT_W-1:0] millivolts;
  logic [TENTHS_W-1:0] voltage_tenths;
  logic [LEVEL_W-1:0]  level_half_percent;
  modport source (output valid, output millivolts, output voltage_tenths,
                  output level_half_percent, input ready);
  modport sink   (input valid, input millivolts, input voltage_tenths,
                  input level_half_percent, output ready);
endinterface

interface bli_cfg_if;
  import bli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BP_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/bli_div_stage.sv @@
// One registered restoring-division stage resolving DIV_STEP quotient bits.
module bli_div_stage #(
  parameter int HI = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  bli_pkg::div_t in_d,
  output logic          out_v,
  output bli_pkg::div_t out_d
);
  import bli_pkg::*;

  logic  v_r;
  div_t  d_r;
  div_t  d_nxt;

  always_comb begin
    logic [NUM_W-1:0] sub;
    d_nxt = in_d;
    for (int j = 0; j < DIV_STEP; j++) begin
      sub = NUM_W'(d_nxt.wid) << (HI - j);
      if (d_nxt.rem >= sub) begin
        d_nxt.rem = d_nxt.rem - sub;
        d_nxt.quo[HI - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

@@ rtl/core/battery_level_interpolator_core.sv @@
// Battery level interpolator: sample to millivolts, tenths and interpolated capacity.
//
// in_ch carries one ADC sample per request; out_ch returns one result per
// sample (millivolts, rounded tenths of a volt, level in half-percent steps).
// cfg_ch writes breakpoint registers (mV in bits 19..8, capacity in 7..0);
// it is always ready and is meant to be written while no sample is in flight.
//
// The block is a 9-stage pipeline: scale multiply, breakpoint compare and
// tenths reciprocal multiply, segment setup, slope multiply, four restoring
// divide stages of two quotient bits each, then the final capacity add.
// One sample is taken every cycle unless out_ch.ready is low and every stage
// holds a request. The divide stages set the depth.
//
// Reset clears all stage valid bits and loads the default breakpoint table.
// When out_ch.ready is low, each stage holds and empty stages further up keep
// filling, so in_ch.ready drops only once every stage holds a request.
module battery_level_interpolator_core #(
  parameter int BREAKPOINTS = 8,
  parameter int SAMPLE_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  bli_in_if.sink     in_ch,
  bli_out_if.source  out_ch,
  bli_cfg_if.sink    cfg_ch
);
  import bli_pkg::*;

  localparam int PROD_W = ADC_W + MV_OUT_W;
  localparam int MV_W   = (SAMPLE_BITS >= ADC_W) ? MV_OUT_W
                                                 : ADC_W + MV_OUT_W - SAMPLE_BITS;
  localparam logic [ADC_W-1:0] SAMP_MASK = (SAMPLE_BITS >= ADC_W) ? {ADC_W{1'b1}}
      : ADC_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  // Breakpoint registers
  logic [BP_W-1:0] bp_r [BREAKPOINTS];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BREAKPOINTS; k++) begin
        bp_r[k] <= BP_RESET[k];
      end
    end else if (cfg_ch.valid) begin
      for (int k = 0; k < BREAKPOINTS; k++) begin
        if (cfg_ch.index == CFG_IDX_W'(k)) begin
          bp_r[k] <= cfg_ch.data;
        end
      end
    end
  end

  // Stage handshake chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_adv, s2_adv, s3_adv, s4_adv, out_adv;
  logic dv_v   [DIV_ST];
  div_t dv_d   [DIV_ST];
  logic dv_adv [DIV_ST+1];

  assign out_adv         = !out_v_r || out_ch.ready;
  assign dv_adv[DIV_ST]  = out_adv;
  assign s4_adv          = !s4_v_r || dv_adv[0];
  assign s3_adv          = !s3_v_r || s4_adv;
  assign s2_adv          = !s2_v_r || s3_adv;
  assign s1_adv          = !s1_v_r || s2_adv;
  assign in_ch.ready     = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= in_ch.valid;
      if (s2_adv) s2_v_r <= s1_v_r;
      if (s3_adv) s3_v_r <= s2_v_r;
      if (s4_adv) s4_v_r <= s3_v_r;
      if (out_adv) out_v_r <= dv_v[DIV_ST-1];
    end
  end

  // Stage 1: scale to millivolts
  logic [MV_W-1:0]   s1_mv_r, s1_mv_nxt;
  logic [PROD_W-1:0] s1_prod;

  assign s1_prod   = PROD_W'(in_ch.adc_sample & SAMP_MASK) * PROD_W'(FULL_SCALE_MV);
  assign s1_mv_nxt = MV_W'(s1_prod >> SAMPLE_BITS);

  always_ff @(posedge clk) begin
    if (s1_adv) s1_mv_r <= s1_mv_nxt;
  end

  // Stage 2: find the segment, start the tenths divide
  logic [MV_W-1:0]     s2_mv_r;
  logic                s2_pass_r, s2_pass_nxt;
  logic [CAP_W-1:0]    s2_cap_r, s2_cap_nxt, s2_capp_r, s2_capp_nxt;
  logic [BP_MV_W-1:0]  s2_vs_r, s2_vs_nxt, s2_vp_r, s2_vp_nxt;
  logic [TENTHS_W-1:0] s2_ten_r, s2_ten_nxt;
  logic [TEN_X_W+RECIP_W-1:0] s2_ten_prod;

  assign s2_ten_prod = (TEN_X_W+RECIP_W)'(TEN_X_W'(s1_mv_r) + TEN_X_W'(TENTHS_ROUND))
                     * (TEN_X_W+RECIP_W)'(TENTHS_RECIP);
  assign s2_ten_nxt  = TENTHS_W'(s2_ten_prod >> TENTHS_SHIFT);

  always_comb begin
    logic [BREAKPOINTS-1:0] hit;
    for (int k = 0; k < BREAKPOINTS; k++) begin
      hit[k] = s1_mv_r > MV_W'(bp_r[k][BP_W-1:CAP_W]);
    end
    // nothing below: hold the last capacity
    s2_pass_nxt = 1'b1;
    s2_cap_nxt  = bp_r[BREAKPOINTS-1][CAP_W-1:0];
    s2_capp_nxt = bp_r[BREAKPOINTS-1][CAP_W-1:0];
    s2_vs_nxt   = bp_r[BREAKPOINTS-1][BP_W-1:CAP_W];
    s2_vp_nxt   = bp_r[BREAKPOINTS-1][BP_W-1:CAP_W];
    // lowest index wins, so scan upward from the bottom
    for (int k = BREAKPOINTS - 1; k >= 1; k--) begin
      if (hit[k]) begin
        s2_pass_nxt = 1'b0;
        s2_cap_nxt  = bp_r[k][CAP_W-1:0];
        s2_capp_nxt = bp_r[k-1][CAP_W-1:0];
        s2_vs_nxt   = bp_r[k][BP_W-1:CAP_W];
        s2_vp_nxt   = bp_r[k-1][BP_W-1:CAP_W];
      end
    end
    if (hit[0]) begin
      s2_pass_nxt = 1'b1;
      s2_cap_nxt  = bp_r[0][CAP_W-1:0];
      s2_capp_nxt = bp_r[0][CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_mv_r   <= s1_mv_r;
      s2_pass_r <= s2_pass_nxt;
      s2_cap_r  <= s2_cap_nxt;
      s2_capp_r <= s2_capp_nxt;
      s2_vs_r   <= s2_vs_nxt;
      s2_vp_r   <= s2_vp_nxt;
      s2_ten_r  <= s2_ten_nxt;
    end
  end

  // Stage 3: segment width, offset and capacity step
  logic [BP_MV_W-1:0]  s3_diff_r, s3_diff_nxt, s3_wid_r, s3_wid_nxt;
  logic [CAP_W-1:0]    s3_mag_r, s3_mag_nxt, s3_cap_r;
  logic                s3_neg_r, s3_neg_nxt;
  logic [TENTHS_W-1:0] s3_ten_r;
  logic [MV_OUT_W-1:0] s3_mvo_r;
  logic [CAP_W:0]      s3_dc;

  assign s3_dc = {1'b0, s2_capp_r} - {1'b0, s2_cap_r};

  always_comb begin
    if (s2_pass_r) begin
      s3_diff_nxt = '0;
      s3_wid_nxt  = BP_MV_W'(1);
      s3_mag_nxt  = '0;
      s3_neg_nxt  = 1'b0;
    end else begin
      s3_diff_nxt = BP_MV_W'(s2_mv_r - MV_W'(s2_vs_r));
      s3_wid_nxt  = s2_vp_r - s2_vs_r;
      s3_neg_nxt  = s3_dc[CAP_W];
      s3_mag_nxt  = s3_dc[CAP_W] ? CAP_W'(-s3_dc) : s3_dc[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_diff_r <= s3_diff_nxt;
      s3_wid_r  <= s3_wid_nxt;
      s3_mag_r  <= s3_mag_nxt;
      s3_neg_r  <= s3_neg_nxt;
      s3_cap_r  <= s2_cap_r;
      s3_ten_r  <= s2_ten_r;
      s3_mvo_r  <= s2_mv_r[MV_OUT_W-1:0];
    end
  end

  // Stage 4: slope numerator
  div_t s4_d_r, s4_d_nxt;

  always_comb begin
    s4_d_nxt.rem = NUM_W'(s3_diff_r) * NUM_W'(s3_mag_r);
    s4_d_nxt.wid = s3_wid_r;
    s4_d_nxt.quo = '0;
    s4_d_nxt.neg = s3_neg_r;
    s4_d_nxt.cap = s3_cap_r;
    s4_d_nxt.ten = s3_ten_r;
    s4_d_nxt.mvo = s3_mvo_r;
  end

  always_ff @(posedge clk) begin
    if (s4_adv) s4_d_r <= s4_d_nxt;
  end

  // Stages 5..8: truncating divide by the segment width
  for (genvar j = 0; j < DIV_ST; j++) begin : g_div
    assign dv_adv[j] = !dv_v[j] || dv_adv[j+1];
    bli_div_stage #(
      .HI(Q_W - 1 - j * DIV_STEP)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (dv_adv[j]),
      .in_v  ((j == 0) ? s4_v_r : dv_v[(j == 0) ? 0 : j - 1]),
      .in_d  ((j == 0) ? s4_d_r : dv_d[(j == 0) ? 0 : j - 1]),
      .out_v (dv_v[j]),
      .out_d (dv_d[j])
    );
  end

  // Stage 9: apply the signed step and drive the result
  logic [MV_OUT_W-1:0] out_mv_r;
  logic [TENTHS_W-1:0] out_ten_r;
  logic [LEVEL_W-1:0]  out_lvl_r, out_lvl_nxt;
  div_t                fin;

  assign fin         = dv_d[DIV_ST-1];
  assign out_lvl_nxt = fin.neg ? LEVEL_W'(fin.cap - fin.quo) : LEVEL_W'(fin.cap + fin.quo);

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_mv_r  <= fin.mvo;
      out_ten_r <= fin.ten;
      out_lvl_r <= out_lvl_nxt;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.millivolts         = out_mv_r;
  assign out_ch.voltage_tenths     = out_ten_r;
  assign out_ch.level_half_percent = out_lvl_r;

endmodule

@@ rtl/core/bli_checker.sv @@
// Port-level assertions for the battery level interpolator, bound to the top level.
module bli_checker #(
  parameter int SAMPLE_BITS = 14
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_millivolts,
  input logic [5:0]  out_voltage_tenths
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a draining output never blocks new samples
  a_ready_through: assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_tenths_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (SAMPLE_BITS >= 14)) |->
      ((32'(out_voltage_tenths) * 32'd100 <= 32'(out_millivolts) + 32'd50) &&
       (32'(out_millivolts) + 32'd50 < 32'(out_voltage_tenths) * 32'd100 + 32'd100)))
    else $error("tenths disagree with millivolts");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind battery_level_interpolator_core bli_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bli_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_millivolts     (out_ch.millivolts),
  .out_voltage_tenths (out_ch.voltage_tenths)
);
